### src/itra_pkg.sv
// Package for the integer to radix ASCII converter.
// Holds the fixed field widths, character codes, FSM state type and the
// control and status structs shared by the divider and the top level.
package itra_pkg;

   localparam int RADIX_WIDTH = 6;
   localparam int DIGIT_WIDTH = 6;
   localparam int CHAR_WIDTH  = 8;

   localparam logic [CHAR_WIDTH-1:0]  CH_MINUS      = 8'h2D;
   localparam logic [CHAR_WIDTH-1:0]  CH_ZERO       = 8'h30;
   localparam logic [CHAR_WIDTH-1:0]  CH_LETTER_A   = 8'h41;
   localparam logic [CHAR_WIDTH-1:0]  CH_NONE       = 8'h00;
   localparam logic [RADIX_WIDTH-1:0] DECIMAL_RADIX = 6'd10;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MIN     = 6'd2;
   localparam logic [RADIX_WIDTH-1:0] RADIX_MAX     = 6'd36;
   localparam logic [DIGIT_WIDTH-1:0] DIGIT_TEN     = 6'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ERROR_OUT,
      ST_DIVIDE,
      ST_MINUS_OUT,
      ST_READ,
      ST_DIGIT_OUT
   } itra_state_type;

   // Commands from the sequencer to the serial divider
   typedef struct packed {
      logic start;
      logic load;
   } div_ctrl_type;

   // Status back from the serial divider
   typedef struct packed {
      logic                   done;
      logic                   nonzero;
      logic [DIGIT_WIDTH-1:0] digit;
   } div_stat_type;

   // Map a digit value to its ASCII character, 'A' onward from ten
   function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input logic [DIGIT_WIDTH-1:0] d);
      logic [CHAR_WIDTH-1:0] ch;
      if (d < DIGIT_TEN) begin
         ch = CH_ZERO + {2'b00, d};
      end else begin
         ch = CH_LETTER_A + {2'b00, d - DIGIT_TEN};
      end
      return ch;
   endfunction

endpackage

### src/integer_to_radix_ascii.sv
// Integer to radix ASCII converter, top level.
// Uses itra_pkg, itra_divider and itra_digit_stack.
//
// Usage:
//   req channel: one beat carries a word and a radix. The block converts
//   it and returns its digits on the rsp channel as ASCII characters, most
//   significant first, the final character flagged by rsp_tlast. Radix ten
//   treats the word as signed and prefixes '-' for negative values; other
//   radixes treat it as unsigned. A radix outside 2 to 36 gives one beat
//   with character zero, rsp_tlast and rsp_tuser (error) set.
//   Sequence: each digit takes one divider pass over the VALUE_WIDTH-bit word
//   and is then pushed into the digit store; each character is emitted
//   by a store read and an output load, and a leading '-' by an output
//   load alone. The next request is taken once the last character is in
//   the output register.
//   Reset clears the sequencer and the output valid flag.
//   A stalled receiver holds the output register; the sequencer waits
//   until the current beat is taken before loading the next character.
module integer_to_radix_ascii
   import itra_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic clock,
   input  logic reset,
   // req_tdata fields, lowest bit up: value[VALUE_WIDTH], radix[6], zero pad
   input  logic [((VALUE_WIDTH + RADIX_WIDTH + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rsp_tdata fields, lowest bit up: character[8]
   output logic [CHAR_WIDTH-1:0] rsp_tdata,
   output logic                  rsp_tlast,
   // rsp_tuser fields, lowest bit up: error[1]
   output logic                  rsp_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready
);

   localparam int AW = $clog2(VALUE_WIDTH);
   localparam int PW = $clog2(VALUE_WIDTH + 1);

   itra_state_type state_ff, state_in;

   logic [PW-1:0]         ptr_ff, ptr_in;
   logic                  neg_ff, neg_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0] rsp_char_ff, rsp_char_in;
   logic                  rsp_last_ff, rsp_last_in;
   logic                  rsp_err_ff, rsp_err_in;

   logic [VALUE_WIDTH-1:0] in_value;
   logic [RADIX_WIDTH-1:0] in_radix;
   logic [VALUE_WIDTH-1:0] in_mag;
   logic                   in_bad;
   logic                   in_neg;
   logic                   accept;
   logic                   out_free;
   logic                   out_load;
   logic [CHAR_WIDTH-1:0]  out_char;
   logic                   out_last;
   logic                   out_err;
   logic [PW-1:0]          ptr_dec;

   div_ctrl_type           div_ctrl;
   div_stat_type           div_stat;
   logic                   push;
   logic                   pop;
   logic [DIGIT_WIDTH-1:0] pop_digit;

   // Unpack the request beat and take the magnitude
   always_comb begin
      in_value = req_tdata[VALUE_WIDTH-1:0];
      in_radix = req_tdata[VALUE_WIDTH +: RADIX_WIDTH];
      in_bad   = (in_radix < RADIX_MIN) || (in_radix > RADIX_MAX);
      in_neg   = (in_radix == DECIMAL_RADIX) && in_value[VALUE_WIDTH-1];
      in_mag   = in_neg ? (~in_value + 1'b1) : in_value;
      accept   = req_tvalid && req_tready;
      out_free = !rsp_valid_ff || rsp_tready;
      ptr_dec  = ptr_ff - 1'b1;
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = in_bad ? ST_ERROR_OUT : ST_DIVIDE;
            end
         end
         ST_ERROR_OUT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_DIVIDE: begin
            if (div_stat.done && !div_stat.nonzero) begin
               state_in = neg_ff ? ST_MINUS_OUT : ST_READ;
            end
         end
         ST_MINUS_OUT: begin
            if (out_free) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DIGIT_OUT;
         end
         ST_DIGIT_OUT: begin
            if (out_free) begin
               state_in = (ptr_ff == '0) ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      div_ctrl      = '0;
      push          = 1'b0;
      pop           = 1'b0;
      ptr_in        = ptr_ff;
      neg_in        = neg_ff;
      out_load      = 1'b0;
      out_char      = CH_NONE;
      out_last      = 1'b0;
      out_err       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               neg_in = in_neg;
               ptr_in = '0;
               if (!in_bad) begin
                  div_ctrl.start = 1'b1;
                  div_ctrl.load  = 1'b1;
               end
            end
         end
         ST_ERROR_OUT: begin
            out_load = out_free;
            out_char = CH_NONE;
            out_last = 1'b1;
            out_err  = 1'b1;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               push   = 1'b1;
               ptr_in = ptr_ff + 1'b1;
               if (div_stat.nonzero) begin
                  div_ctrl.start = 1'b1;
               end
            end
         end
         ST_MINUS_OUT: begin
            out_load = out_free;
            out_char = CH_MINUS;
         end
         ST_READ: begin
            pop    = 1'b1;
            ptr_in = ptr_dec;
         end
         ST_DIGIT_OUT: begin
            out_load = out_free;
            out_char = digit_to_char(pop_digit);
            out_last = (ptr_ff == '0);
         end
         default: begin
            out_load = 1'b0;
         end
      endcase
   end

   // Output register: load a new beat or drop the taken one
   always_comb begin
      rsp_char_in = rsp_char_ff;
      rsp_last_in = rsp_last_ff;
      rsp_err_in  = rsp_err_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_char_in  = out_char;
         rsp_last_in  = out_last;
         rsp_err_in   = out_err;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_err_ff  <= rsp_err_in;
      ptr_ff      <= ptr_in;
      neg_ff      <= neg_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   itra_divider #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_divider (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (div_ctrl),
      .load_value (in_mag),
      .load_radix (in_radix),
      .stat       (div_stat)
   );

   itra_digit_stack #(
      .DEPTH (VALUE_WIDTH)
   ) u_digit_stack (
      .clock   (clock),
      .wr_en   (push),
      .wr_addr (ptr_ff[AW-1:0]),
      .wr_data (div_stat.digit),
      .rd_en   (pop),
      .rd_addr (ptr_dec[AW-1:0]),
      .rd_data (pop_digit)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_char_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_err_ff;

endmodule

### src/itra_divider.sv
// Bit-serial restoring divider: divides a held word by the radix, one
// quotient bit per cycle, leaving the quotient in place for the next pass.
// Depends on itra_pkg for the control and status structs.
module itra_divider
   import itra_pkg::*;
#(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  div_ctrl_type           ctrl,
   input  logic [VALUE_WIDTH-1:0] load_value,
   input  logic [RADIX_WIDTH-1:0] load_radix,
   output div_stat_type           stat
);

   localparam int CW = $clog2(VALUE_WIDTH);

   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [DIGIT_WIDTH-1:0] rem_ff, rem_in;
   logic [RADIX_WIDTH-1:0] radix_ff, radix_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;
   logic                   nz_ff, nz_in;
   logic                   done_ff, done_in;

   logic [DIGIT_WIDTH:0]   trial;
   logic [DIGIT_WIDTH:0]   diff;
   logic                   ge;

   // Shift the next dividend bit into the partial remainder and trial-subtract
   always_comb begin
      trial = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      diff  = trial - {1'b0, radix_ff};
      ge    = (trial >= {1'b0, radix_ff});
   end

   // Start a pass on ctrl.start, else advance one quotient bit per cycle while busy
   always_comb begin
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      radix_in = radix_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      nz_in    = nz_ff;
      done_in  = 1'b0;
      if (ctrl.start) begin
         rem_in  = '0;
         cnt_in  = CW'(VALUE_WIDTH - 1);
         busy_in = 1'b1;
         nz_in   = 1'b0;
         if (ctrl.load) begin
            quo_in   = load_value;
            radix_in = load_radix;
         end
      end else if (busy_ff) begin
         quo_in = {quo_ff[VALUE_WIDTH-2:0], ge};
         rem_in = ge ? diff[DIGIT_WIDTH-1:0] : trial[DIGIT_WIDTH-1:0];
         nz_in  = nz_ff | ge;
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      rem_ff   <= rem_in;
      radix_ff <= radix_in;
      cnt_ff   <= cnt_in;
      nz_ff    <= nz_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign stat.done    = done_ff;
   assign stat.nonzero = nz_ff;
   assign stat.digit   = rem_ff;

endmodule

### src/itra_digit_stack.sv
// Digit store: holds the digits of one conversion, least significant first,
// so they can be read back in reverse. Uses itra_pkg for the digit width.
module itra_digit_stack
   import itra_pkg::*;
#(
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DIGIT_WIDTH-1:0]   wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DIGIT_WIDTH-1:0]   rd_data
);

   logic [DIGIT_WIDTH-1:0] mem [DEPTH];

   // Write one digit per push
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
